[src/cqfr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// cqfr_pkg
// Shared types, constants and helpers for the circular queue find/remove unit.
// ============================================================================
package cqfr_pkg;

    // Ring depth and the widths that follow from it.
    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int BYTE_W = 8;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [BYTE_W-1:0]       byte_t;

    // Command codes.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FIND
    } state_t;

    // One cycle's worth of requests to the entry memory.
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        key_t  wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } mem_req_t;

    // Advance a ring index by one, wrapping at the depth.
    function automatic addr_t wrap_inc(addr_t a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : addr_t'(a + ADDR_W'(1));
    endfunction

    // Fit a count into an 8-bit result field.
    function automatic byte_t to_byte(cnt_t c);
        logic [CNT_W+BYTE_W-1:0] ext;
        ext = {{BYTE_W{1'b0}}, c};
        return ext[BYTE_W-1:0];
    endfunction

endpackage

[src/circular_queue_find_remove_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// circular_queue_find_remove_unit
// Circular queue of signed keys with push, pop and find-with-rotate-and-remove.
// ============================================================================
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+--------------------------------------
//  input   | in_valid / in_stall      | command, key
//  output  | out_valid / out_stall    | status, data, moves, occupancy
//
// Push, a failing command and an unused command give their result in the
// cycle after the item is taken. Pop first reads the head entry from memory.
// A find reads one entry per cycle, copying each mismatch to the tail, until
// it removes a matching key or every held key has gone round once.
// Reset clears the state, indices, count and output valid; entries need no clearing.
// While the output holds an untaken item that is stalled, the input waits.
// ============================================================================
module circular_queue_find_remove_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic [7:0]         moves,
    output logic [7:0]         occupancy
);

    cqfr_pkg::state_t state_reg, state_next;
    cqfr_pkg::addr_t  head_reg, head_next;
    cqfr_pkg::addr_t  tail_reg, tail_next;
    cqfr_pkg::cnt_t   count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    cqfr_pkg::key_t   key_reg, key_next;
    cqfr_pkg::addr_t  cmp_ptr_reg, cmp_ptr_next;
    cqfr_pkg::addr_t  wr_ptr_reg, wr_ptr_next;
    cqfr_pkg::cnt_t   cmp_i_reg, cmp_i_next;

    logic [1:0]       status_reg, status_next;
    cqfr_pkg::key_t   data_reg, data_next;
    cqfr_pkg::byte_t  moves_reg, moves_next;
    cqfr_pkg::byte_t  occ_reg, occ_next;

    cqfr_pkg::mem_req_t mem_req;
    cqfr_pkg::key_t     rd_data;

    logic accept;
    logic out_free;
    logic load_out;
    logic is_full;
    logic is_empty;
    logic match;
    logic last_move;

    // Entry memory.
    cqfr_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Handshake and status terms.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != cqfr_pkg::ST_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign is_full   = (count_reg == cqfr_pkg::CNT_W'(cqfr_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign match     = (rd_data == key_reg);
    assign last_move = (cmp_i_reg == cqfr_pkg::cnt_t'(count_reg - cqfr_pkg::CNT_W'(1)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cqfr_pkg::ST_IDLE:
            begin
                if (accept && !is_empty)
                begin
                    if (command == cqfr_pkg::CMD_POP)
                    begin
                        state_next = cqfr_pkg::ST_POP;
                    end
                    else if (command == cqfr_pkg::CMD_FIND)
                    begin
                        state_next = cqfr_pkg::ST_FIND;
                    end
                end
            end
            cqfr_pkg::ST_POP:
            begin
                if (out_free)
                begin
                    state_next = cqfr_pkg::ST_IDLE;
                end
            end
            cqfr_pkg::ST_FIND:
            begin
                if (out_free && (match || last_move))
                begin
                    state_next = cqfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cqfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and results.
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        cmp_ptr_next = cmp_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        cmp_i_next   = cmp_i_reg;
        load_out     = 1'b0;
        status_next  = cqfr_pkg::STAT_OK;
        data_next    = '0;
        moves_next   = '0;
        occ_next     = cqfr_pkg::to_byte(count_reg);
        mem_req      = '0;

        unique case (state_reg)
            cqfr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        cqfr_pkg::CMD_PUSH:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                status_next = cqfr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = tail_reg;
                                mem_req.wr_data = key;
                                tail_next       = cqfr_pkg::wrap_inc(tail_reg);
                                count_next      = cqfr_pkg::cnt_t'(count_reg + 1'b1);
                                occ_next        = cqfr_pkg::to_byte(count_next);
                            end
                        end
                        cqfr_pkg::CMD_POP:
                        begin
                            if (is_empty)
                            begin
                                load_out    = 1'b1;
                                status_next = cqfr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg;
                            end
                        end
                        cqfr_pkg::CMD_FIND:
                        begin
                            if (is_empty)
                            begin
                                load_out    = 1'b1;
                                status_next = cqfr_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg;
                                key_next        = key;
                                cmp_ptr_next    = head_reg;
                                wr_ptr_next     = tail_reg;
                                cmp_i_next      = '0;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            // Pop: the head entry has arrived from memory.
            cqfr_pkg::ST_POP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    data_next  = rd_data;
                    head_next  = cqfr_pkg::wrap_inc(head_reg);
                    count_next = cqfr_pkg::cnt_t'(count_reg - 1'b1);
                    occ_next   = cqfr_pkg::to_byte(count_next);
                end
            end

            // Find: compare one entry per cycle while the output is free; a mismatch is
            // copied to the tail while the next entry, if any, is read.
            cqfr_pkg::ST_FIND:
            begin
                if (out_free)
                begin
                    if (match)
                    begin
                        load_out   = 1'b1;
                        data_next  = key_reg;
                        moves_next = cqfr_pkg::to_byte(cmp_i_reg);
                        head_next  = cqfr_pkg::wrap_inc(cmp_ptr_reg);
                        tail_next  = wr_ptr_reg;
                        count_next = cqfr_pkg::cnt_t'(count_reg - 1'b1);
                        occ_next   = cqfr_pkg::to_byte(count_next);
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = wr_ptr_reg;
                        mem_req.wr_data = rd_data;
                        if (last_move)
                        begin
                            // Every held entry went round once: order restored.
                            load_out    = 1'b1;
                            status_next = cqfr_pkg::STAT_NOT_FOUND;
                            moves_next  = cqfr_pkg::to_byte(count_reg);
                            head_next   = cqfr_pkg::wrap_inc(cmp_ptr_reg);
                            tail_next   = cqfr_pkg::wrap_inc(wr_ptr_reg);
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = cqfr_pkg::wrap_inc(cmp_ptr_reg);
                            cmp_ptr_next    = cqfr_pkg::wrap_inc(cmp_ptr_reg);
                            wr_ptr_next     = cqfr_pkg::wrap_inc(wr_ptr_reg);
                            cmp_i_next      = cqfr_pkg::cnt_t'(cmp_i_reg + 1'b1);
                        end
                    end
                end
            end

            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Output holding register valid.
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cqfr_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and result payload registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_ptr_reg <= cmp_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        cmp_i_reg   <= cmp_i_next;
        if (load_out)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            moves_reg  <= moves_next;
            occ_reg    <= occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign moves     = moves_reg;
    assign occupancy = occ_reg;

    // Ring bookkeeping: the tail sits count entries past the head.
    logic [cqfr_pkg::CNT_W:0] ring_sum;
    logic [cqfr_pkg::CNT_W:0] ring_mod;

    assign ring_sum = (cqfr_pkg::CNT_W+1)'(head_reg) + (cqfr_pkg::CNT_W+1)'(count_reg);
    assign ring_mod = (ring_sum >= (cqfr_pkg::CNT_W+1)'(cqfr_pkg::DEPTH))
                    ? (ring_sum - (cqfr_pkg::CNT_W+1)'(cqfr_pkg::DEPTH)) : ring_sum;

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cqfr_pkg::CNT_W'(cqfr_pkg::DEPTH))
        else $error("held count exceeds depth");

    // Between commands the tail is the head advanced by the count.
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqfr_pkg::ST_IDLE) |-> (tail_reg == cqfr_pkg::addr_t'(ring_mod)))
        else $error("head, tail and count disagree");

    // A find walk never goes past the held entries.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqfr_pkg::ST_FIND) |-> (cmp_i_reg < count_reg))
        else $error("find walk past held count");

    // A successful push grows the queue by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == cqfr_pkg::CMD_PUSH && !is_full)
        |=> (count_reg == cqfr_pkg::cnt_t'($past(count_reg) + 1'b1)))
        else $error("push did not add one entry");

endmodule

[src/cqfr_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// cqfr_ram
// Entry store of the ring: one write port and one read port, registered read.
// ============================================================================
module cqfr_ram (
    input  logic              clk,
    input  cqfr_pkg::mem_req_t req,
    output cqfr_pkg::key_t    rd_data
);

    cqfr_pkg::key_t mem [cqfr_pkg::DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
